// ===== src/eoi_pkg.sv =====
package eoi_pkg;

  // Fixed field widths
  localparam int WORD_W = 32;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // CORDIC iteration count (8 to 30)
  localparam int CORDIC_STEPS = 16;

  // Fraction bits
  localparam int HEAD_FRAC = 16;   // heading product is Q16.16 * Q16.16
  localparam int Q30_FRAC  = 30;   // trig values and angles
  localparam int ANG_SHIFT = Q30_FRAC - HEAD_FRAC;

  // Datapath widths
  localparam int DELTA_W = WORD_W + 1;         // linear delta, never wraps
  localparam int XY_W    = WORD_W + 1;         // CORDIC x / y
  localparam int Z_W     = WORD_W + 2;         // CORDIC angle, Q2.30 plus headroom
  localparam int MUL_W   = DELTA_W + XY_W;     // shared multiplier product
  localparam int RED_W   = WORD_W + ANG_SHIFT; // |heading| in Q30
  localparam int DX_W    = WORD_W + 3;         // rounded position increment
  localparam int ATAN_W  = 30;
  localparam int ATAN_IDX_W = 5;

  // Modulo 2*pi reduction: quotient of |heading| * 2^14 by 2*pi is below 2^13
  localparam int MOD_TOP = 12;

  localparam int CNT_MAX = (CORDIC_STEPS > MOD_TOP + 1) ? CORDIC_STEPS : MOD_TOP + 1;
  localparam int CNT_W   = $clog2(CNT_MAX);
  localparam logic [CNT_W-1:0] CNT_MOD_TOP = CNT_W'(MOD_TOP);
  localparam logic [CNT_W-1:0] CNT_ROT_LAST = CNT_W'(CORDIC_STEPS - 1);

  // Q30 constants
  localparam logic [RED_W-1:0]       TWO_PI_RED    = RED_W'(64'd6746518852);
  localparam logic signed [Z_W-1:0]  Z_TWO_PI      = Z_W'(64'd6746518852);
  localparam logic signed [Z_W-1:0]  Z_PI          = Z_W'(64'd3373259426);
  localparam logic signed [Z_W-1:0]  Z_HALF_PI     = Z_W'(64'd1686629713);
  localparam logic signed [Z_W-1:0]  Z_NEG_HALF_PI = -Z_HALF_PI;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN   = XY_W'(64'd652032874);

  // Microcode
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,   // take the sample, linear delta, heading product
    OP_HEAD,    // scale and saturate heading
    OP_ABS,     // |heading| in Q30, remember sign
    OP_MOD,     // one conditional subtract of 2*pi << cnt
    OP_WRAP,    // into (-pi, pi]
    OP_FOLD,    // into [-pi/2, pi/2], seed CORDIC
    OP_ROT,     // one CORDIC rotation
    OP_MULX,    // delta * cos
    OP_MULY,    // delta * sin, round x increment
    OP_ACCX,    // accumulate x, round y increment
    OP_ACCY     // accumulate y, load output register
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_WAIT_IN,
    C_LOOP_DN,
    C_LOOP_UP,
    C_WAIT_OUT,
    C_JUMP
  } cond_t;

  localparam int UCODE_LEN = 11;
  localparam int PC_W = $clog2(UCODE_LEN);

  localparam logic [PC_W-1:0] STEP_IDLE = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_HEAD = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_ABS  = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_MOD  = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_WRAP = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_FOLD = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_ROT  = PC_W'(6);
  localparam logic [PC_W-1:0] STEP_MULX = PC_W'(7);
  localparam logic [PC_W-1:0] STEP_MULY = PC_W'(8);
  localparam logic [PC_W-1:0] STEP_ACCX = PC_W'(9);
  localparam logic [PC_W-1:0] STEP_ACCY = PC_W'(10);

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucw_t;

  // Control store
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    case (pc)
      STEP_IDLE: w = '{op: OP_LATCH, cond: C_WAIT_IN,  target: STEP_IDLE};
      STEP_HEAD: w = '{op: OP_HEAD,  cond: C_NEXT,     target: STEP_IDLE};
      STEP_ABS:  w = '{op: OP_ABS,   cond: C_NEXT,     target: STEP_IDLE};
      STEP_MOD:  w = '{op: OP_MOD,   cond: C_LOOP_DN,  target: STEP_MOD};
      STEP_WRAP: w = '{op: OP_WRAP,  cond: C_NEXT,     target: STEP_IDLE};
      STEP_FOLD: w = '{op: OP_FOLD,  cond: C_NEXT,     target: STEP_IDLE};
      STEP_ROT:  w = '{op: OP_ROT,   cond: C_LOOP_UP,  target: STEP_ROT};
      STEP_MULX: w = '{op: OP_MULX,  cond: C_NEXT,     target: STEP_IDLE};
      STEP_MULY: w = '{op: OP_MULY,  cond: C_NEXT,     target: STEP_IDLE};
      STEP_ACCX: w = '{op: OP_ACCX,  cond: C_NEXT,     target: STEP_IDLE};
      STEP_ACCY: w = '{op: OP_ACCY,  cond: C_WAIT_OUT, target: STEP_IDLE};
      default:   w = '{op: OP_NOP,   cond: C_JUMP,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // Q30 arctangent of 2^-i
  function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] i);
    logic [ATAN_W-1:0] a;
    case (i)
      0:  a = ATAN_W'(843314857);
      1:  a = ATAN_W'(497837829);
      2:  a = ATAN_W'(263043837);
      3:  a = ATAN_W'(133525159);
      4:  a = ATAN_W'(67021687);
      5:  a = ATAN_W'(33543516);
      6:  a = ATAN_W'(16775851);
      7:  a = ATAN_W'(8388437);
      8:  a = ATAN_W'(4194283);
      9:  a = ATAN_W'(2097149);
      10: a = ATAN_W'(1048576);
      11: a = ATAN_W'(524288);
      12: a = ATAN_W'(262144);
      13: a = ATAN_W'(131072);
      14: a = ATAN_W'(65536);
      15: a = ATAN_W'(32768);
      16: a = ATAN_W'(16384);
      17: a = ATAN_W'(8192);
      18: a = ATAN_W'(4096);
      19: a = ATAN_W'(2048);
      20: a = ATAN_W'(1024);
      21: a = ATAN_W'(512);
      22: a = ATAN_W'(256);
      23: a = ATAN_W'(128);
      24: a = ATAN_W'(64);
      25: a = ATAN_W'(32);
      26: a = ATAN_W'(16);
      27: a = ATAN_W'(8);
      28: a = ATAN_W'(4);
      29: a = ATAN_W'(2);
      30: a = ATAN_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== src/eoi_in_if.sv =====
interface eoi_in_if import eoi_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t lin_count;
  word_t rot_count;

  modport source (output valid, output lin_count, output rot_count, input ready);
  modport sink   (input valid, input lin_count, input rot_count, output ready);
endinterface

// ===== src/eoi_out_if.sv =====
interface eoi_out_if import eoi_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t pos_x;
  word_t pos_y;
  word_t heading;

  modport source (output valid, output pos_x, output pos_y, output heading, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

// ===== src/encoder_odometry_integrator.sv =====
// Dead-reckoning odometry: each encoder sample (absolute linear and rotation
// readings, Q16.16) produces one result with the saturating x/y position and
// the heading (rotation reading times cfg inv_enc_distance, Q16.16 radians,
// not wrapped). A small microcoded sequencer drives one shared 33x33
// multiplier, a modulo-2*pi reduction unit (one conditional subtract per
// cycle) and a CORDIC rotator (one iteration per cycle). One sample is in
// flight at a time: after an input transfer, the next one is taken only once
// every step has run, in order: accept, heading scale and absolute value,
// the reduction subtracts, wrap and fold, the CORDIC iterations, and the
// products and accumulators. The result lands in an output register in the
// last step; if the previous result is still untaken, the last step waits
// for it. Write the register only while no sample is in flight.
module encoder_odometry_integrator import eoi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  eoi_in_if.sink           in_ch,
  eoi_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata
);

  // Rounded Q30 product: half up, then floor shift
  function automatic logic signed [DX_W-1:0] round_q30(input logic signed [MUL_W-1:0] p);
    logic signed [MUL_W-Q30_FRAC+1:0] t;
    t = $signed(p[MUL_W-1:Q30_FRAC-1]);
    t = t + 1;
    return DX_W'(t >>> 1);
  endfunction

  // Saturating accumulate
  function automatic word_t sat_add(input word_t a, input logic signed [DX_W-1:0] d);
    logic signed [DX_W:0] s;
    s = (DX_W+1)'(a) + (DX_W+1)'(d);
    if ((&s[DX_W:WORD_W-1]) || (~|s[DX_W:WORD_W-1])) begin
      return s[WORD_W-1:0];
    end
    return s[DX_W] ? WORD_MIN : WORD_MAX;
  endfunction

  // Sequencer state
  logic [PC_W-1:0]  pc_r,  pc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  ucw_t             cw;

  // Architectural state
  logic [WORD_W-1:0] inv_r, inv_nxt;
  word_t             last_lin_r, last_lin_nxt;
  word_t             acc_x_r, acc_x_nxt;
  word_t             acc_y_r, acc_y_nxt;

  // Datapath registers
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;
  logic signed [MUL_W-1:0]   prod_r, prod_nxt;
  word_t                     heading_r, heading_nxt;
  logic [RED_W-1:0]          red_r, red_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [Z_W-1:0]     z_r, z_nxt;
  logic signed [XY_W-1:0]    x_r, x_nxt;
  logic signed [XY_W-1:0]    y_r, y_nxt;
  logic signed [DX_W-1:0]    dx_r, dx_nxt;
  logic signed [DX_W-1:0]    dy_r, dy_nxt;

  // Output register
  logic  out_valid_r, out_valid_nxt;
  word_t pos_x_r, pos_x_nxt;
  word_t pos_y_r, pos_y_nxt;
  word_t head_out_r, head_out_nxt;

  logic in_xfer;
  logic out_free;
  logic step_go;

  // Shared multiplier
  logic signed [DELTA_W-1:0] mul_a;
  logic signed [XY_W-1:0]    mul_b;
  logic signed [MUL_W-1:0]   mul_p;

  // Per-op temporaries
  logic [WORD_W-1:0]        abs_head;
  logic [RED_W-1:0]         mod_sub;
  logic signed [Z_W-1:0]    rz;
  logic signed [XY_W-1:0]   xs, ys;
  logic signed [Z_W-1:0]    at;

  assign cw = ucode(pc_r);

  assign in_ch.ready    = (cw.cond == C_WAIT_IN);
  assign in_xfer        = in_ch.valid && in_ch.ready;
  assign out_free       = !out_valid_r || out_ch.ready;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.pos_x   = pos_x_r;
  assign out_ch.pos_y   = pos_y_r;
  assign out_ch.heading = head_out_r;

  // Step sequencing
  always_comb begin
    step_go = 1'b1;
    pc_nxt  = pc_r;
    case (cw.cond)
      C_NEXT: begin
        pc_nxt = pc_r + PC_W'(1);
      end
      C_WAIT_IN: begin
        step_go = in_xfer;
        pc_nxt  = in_xfer ? pc_r + PC_W'(1) : pc_r;
      end
      C_LOOP_DN: begin
        pc_nxt = (cnt_r != '0) ? cw.target : pc_r + PC_W'(1);
      end
      C_LOOP_UP: begin
        pc_nxt = (cnt_r != CNT_ROT_LAST) ? cw.target : pc_r + PC_W'(1);
      end
      C_WAIT_OUT: begin
        step_go = out_free;
        pc_nxt  = out_free ? cw.target : pc_r;
      end
      C_JUMP: begin
        pc_nxt = cw.target;
      end
      default: begin
        pc_nxt = STEP_IDLE;
      end
    endcase
  end

  // Multiplier operand select
  always_comb begin
    case (cw.op)
      OP_LATCH: begin
        mul_a = DELTA_W'(in_ch.rot_count);
        mul_b = $signed({1'b0, inv_r});
      end
      OP_MULX: begin
        mul_a = delta_r;
        mul_b = x_r;
      end
      default: begin
        mul_a = delta_r;
        mul_b = y_r;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Datapath
  always_comb begin
    cnt_nxt       = cnt_r;
    last_lin_nxt  = last_lin_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    delta_nxt     = delta_r;
    prod_nxt      = prod_r;
    heading_nxt   = heading_r;
    red_nxt       = red_r;
    neg_nxt       = neg_r;
    z_nxt         = z_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    head_out_nxt  = head_out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    abs_head = heading_r[WORD_W-1] ? WORD_W'(-heading_r) : WORD_W'(heading_r);
    mod_sub  = TWO_PI_RED << cnt_r;
    rz       = $signed({1'b0, red_r[Z_W-2:0]});
    xs       = x_r >>> cnt_r;
    ys       = y_r >>> cnt_r;
    at       = $signed({{(Z_W-ATAN_W){1'b0}}, atan_q30(ATAN_IDX_W'(cnt_r))});

    case (cw.op)
      OP_LATCH: begin
        if (step_go) begin
          last_lin_nxt = in_ch.lin_count;
          delta_nxt    = DELTA_W'(in_ch.lin_count) - DELTA_W'(last_lin_r);
          prod_nxt     = mul_p;
        end
      end
      OP_HEAD: begin
        // floor(prod / 2^16), clamped to 32 bits
        if ((&prod_r[MUL_W-1:WORD_W+HEAD_FRAC-1]) ||
            (~|prod_r[MUL_W-1:WORD_W+HEAD_FRAC-1])) begin
          heading_nxt = prod_r[WORD_W+HEAD_FRAC-1:HEAD_FRAC];
        end else begin
          heading_nxt = prod_r[MUL_W-1] ? WORD_MIN : WORD_MAX;
        end
      end
      OP_ABS: begin
        red_nxt = {abs_head, {ANG_SHIFT{1'b0}}};
        neg_nxt = heading_r[WORD_W-1];
        cnt_nxt = CNT_MOD_TOP;
      end
      OP_MOD: begin
        if (red_r >= mod_sub) begin
          red_nxt = red_r - mod_sub;
        end
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      OP_WRAP: begin
        // Signed floor-mod, then into (-pi, pi]
        if (!neg_r) begin
          z_nxt = (rz > Z_PI) ? rz - Z_TWO_PI : rz;
        end else if (rz == '0) begin
          z_nxt = '0;
        end else if (rz < Z_PI) begin
          z_nxt = -rz;
        end else begin
          z_nxt = Z_TWO_PI - rz;
        end
      end
      OP_FOLD: begin
        // A half-turn fold negates cos and sin; applied to the delta instead
        if (z_r > Z_HALF_PI) begin
          z_nxt     = z_r - Z_PI;
          delta_nxt = -delta_r;
        end else if (z_r < Z_NEG_HALF_PI) begin
          z_nxt     = z_r + Z_PI;
          delta_nxt = -delta_r;
        end
        x_nxt   = CORDIC_GAIN;
        y_nxt   = '0;
        cnt_nxt = '0;
      end
      OP_ROT: begin
        if (!z_r[Z_W-1]) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + at;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      OP_MULX: begin
        prod_nxt = mul_p;
      end
      OP_MULY: begin
        dx_nxt   = round_q30(prod_r);
        prod_nxt = mul_p;
      end
      OP_ACCX: begin
        acc_x_nxt = sat_add(acc_x_r, dx_r);
        dy_nxt    = round_q30(prod_r);
      end
      OP_ACCY: begin
        if (step_go) begin
          acc_y_nxt     = sat_add(acc_y_r, dy_r);
          pos_x_nxt     = acc_x_r;
          pos_y_nxt     = acc_y_nxt;
          head_out_nxt  = heading_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Register write
  assign inv_nxt = cfg_we ? cfg_wdata : inv_r;

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      inv_r       <= WORD_W'(65536);
      last_lin_r  <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      inv_r       <= inv_nxt;
      last_lin_r  <= last_lin_nxt;
      acc_x_r     <= acc_x_nxt;
      acc_y_r     <= acc_y_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    delta_r    <= delta_nxt;
    prod_r     <= prod_nxt;
    heading_r  <= heading_nxt;
    red_r      <= red_nxt;
    neg_r      <= neg_nxt;
    z_r        <= z_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    pos_x_r    <= pos_x_nxt;
    pos_y_r    <= pos_y_nxt;
    head_out_r <= head_out_nxt;
  end

`ifndef SYNTHESIS
  // A transfer always starts the heading step
  a_xfer_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (pc_r == STEP_HEAD))
    else $error("sample transfer not followed by heading step");

  // A result only appears from the final step
  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(pc_r) == STEP_ACCY))
    else $error("result loaded outside the final step");

  // Reduction counter stays in the shift range
  a_mod_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == OP_MOD) |-> (cnt_r <= CNT_MOD_TOP))
    else $error("reduction shift out of range");

  // Reduction leaves a remainder below 2*pi
  a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == OP_WRAP) |-> (red_r < TWO_PI_RED))
    else $error("angle reduction incomplete");

  // CORDIC starts inside its convergence range
  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((cw.op == OP_ROT) && (cnt_r == '0)) |-> ((z_r <= Z_HALF_PI) && (z_r >= Z_NEG_HALF_PI)))
    else $error("CORDIC angle outside [-pi/2, pi/2]");
`endif

endmodule
